/* sv/brl_pkg.sv */
// ----------------------------------------------------------------------------
// Byte-range lock table package
// Shared sizes, request codes, status codes and the controller-to-datapath
// command bundle.
// ----------------------------------------------------------------------------
package brl_pkg;

  localparam int NumEntries = 16;
  localparam int OwnerBits  = 16;
  localparam int FileBits   = 16;
  localparam int IdxBits    = (NumEntries > 1) ? $clog2(NumEntries) : 1;
  localparam int PosBits    = 34;

  // Offset 2^31 - 1; a zero length reaches up to it.
  localparam longint IntMax = 64'sd2147483647;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_ACCESS  = 3'd2;
  localparam logic [2:0] ST_BLOCK   = 3'd3;
  localparam logic [2:0] ST_NOFREE  = 3'd4;
  localparam logic [2:0] ST_WAIT    = 3'd5;

  localparam logic [1:0] REQ_QUERY = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_SETW  = 2'd2;
  localparam logic [1:0] REQ_BAD   = 2'd3;

  // Lock kinds; an entry holding LK_UNLOCK is free.
  localparam logic [1:0] LK_UNLOCK = 2'd0;
  localparam logic [1:0] LK_READ   = 2'd1;
  localparam logic [1:0] LK_WRITE  = 2'd2;
  localparam logic [1:0] LK_BAD    = 2'd3;

  localparam logic [1:0] WH_START = 2'd0;
  localparam logic [1:0] WH_CUR   = 2'd1;
  localparam logic [1:0] WH_END   = 2'd2;
  localparam logic [1:0] WH_BAD   = 2'd3;

  // Commands from the controller.
  typedef struct packed {
    logic load;       // capture request and compute range
    logic idx_clr;    // restart scan index
    logic idx_inc;    // advance scan index
    logic do_remove;  // free current entry
    logic do_trim_lo; // entry first := last + 1
    logic do_trim_hi; // entry last := first - 1
    logic do_split;   // copy upper part into free entry, trim current
    logic do_insert;  // write new lock into first free entry
    logic set_wake;
    logic report;     // latch current entry as the conflict
  } brl_cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic       bad;       // request fails checks
    logic [2:0] bad_code;
    logic       is_query;
    logic       is_unlock;
    logic       is_setw;   // set request that may wait
    logic       last_idx;
    logic       hit;       // current entry overlaps and conflicts
    logic       covers;    // request covers whole entry
    logic       lo_cov;    // request starts at or before entry
    logic       hi_cov;    // request ends at or after entry
    logic       has_free;  // some entry currently free
  } brl_stat_t;

endpackage

/* sv/byte_range_lock_table.sv */
// ----------------------------------------------------------------------------
// Byte-range lock table
// Table of record locks answering query, set and unlock requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The block then
// checks it, scans the table one entry per cycle in index order and strobes
// done for exactly one cycle with the result; the receiver cannot stall it.
// A request ends early on a failed check, a conflict or a missing free
// entry; otherwise the scan visits every entry. Splitting a lock during an
// unlock uses a free entry found by a priority search in the same cycle,
// so it adds no time. The table resets to all entries free; no clearing
// pass is needed.
module byte_range_lock_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  output logic                          done,
  input  logic [1:0]                    req_type,
  input  logic [1:0]                    lock_mode,
  input  logic [1:0]                    whence,
  input  logic signed [31:0]            start_req,
  input  logic signed [31:0]            length,
  input  logic [30:0]                   cur_pos,
  input  logic [30:0]                   file_size,
  input  logic [brl_pkg::OwnerBits-1:0] owner,
  input  logic [brl_pkg::FileBits-1:0]  file_id,
  input  logic                          can_read,
  input  logic                          can_write,
  input  logic                          is_regular,
  output logic [2:0]                    status,
  output logic                          conflict_found,
  output logic [1:0]                    conflict_type,
  output logic signed [32:0]            conflict_start,
  output logic [32:0]                   conflict_length,
  output logic [brl_pkg::OwnerBits-1:0] conflict_owner,
  output logic                          wake_waiters
);

  brl_pkg::brl_cmd_t  cmd;
  brl_pkg::brl_stat_t stat;
  logic [2:0]         code;
  logic               wake;

  brl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .status(code), .cmd(cmd), .stat(stat)
  );

  brl_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .req_type(req_type), .lock_mode(lock_mode), .whence(whence),
    .start_req(start_req), .length(length), .cur_pos(cur_pos),
    .file_size(file_size), .owner(owner), .file_id(file_id),
    .can_read(can_read), .can_write(can_write), .is_regular(is_regular),
    .rep_type(conflict_type), .rep_start(conflict_start),
    .rep_length(conflict_length), .rep_owner(conflict_owner),
    .rep_found(conflict_found), .wake(wake)
  );

  // The controller already tells would-block from must-wait.
  // Wake-up is only reported for unlock requests.
  assign status = code;
  assign wake_waiters = wake && stat.is_unlock &&
                        (code == brl_pkg::ST_OK || code == brl_pkg::ST_NOFREE);

endmodule

/* sv/brl_datapath.sv */
// ----------------------------------------------------------------------------
// Byte-range lock datapath
// Holds the request, the lock table and the conflict report.
// ----------------------------------------------------------------------------
module brl_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  brl_pkg::brl_cmd_t             cmd,
  output brl_pkg::brl_stat_t            stat,
  input  logic [1:0]                    req_type,
  input  logic [1:0]                    lock_mode,
  input  logic [1:0]                    whence,
  input  logic signed [31:0]            start_req,
  input  logic signed [31:0]            length,
  input  logic [30:0]                   cur_pos,
  input  logic [30:0]                   file_size,
  input  logic [brl_pkg::OwnerBits-1:0] owner,
  input  logic [brl_pkg::FileBits-1:0]  file_id,
  input  logic                          can_read,
  input  logic                          can_write,
  input  logic                          is_regular,
  output logic [1:0]                    rep_type,
  output logic signed [32:0]            rep_start,
  output logic [32:0]                   rep_length,
  output logic [brl_pkg::OwnerBits-1:0] rep_owner,
  output logic                          rep_found,
  output logic                          wake
);

  localparam int P = brl_pkg::PosBits;
  localparam int N = brl_pkg::NumEntries;
  localparam int I = brl_pkg::IdxBits;

  logic [1:0]                    r_req, r_lt;
  logic [brl_pkg::OwnerBits-1:0] r_own;
  logic [brl_pkg::FileBits-1:0]  r_fid;
  logic signed [P-1:0]           first, last;
  logic                          bad;
  logic [2:0]                    bad_code;

  logic [1:0]                    e_type  [N];
  logic [brl_pkg::OwnerBits-1:0] e_owner [N];
  logic [brl_pkg::FileBits-1:0]  e_file  [N];
  logic signed [P-1:0]           e_first [N];
  logic signed [P-1:0]           e_last  [N];

  logic [I-1:0] idx;
  logic [I-1:0] free_idx;
  logic         free_any;

  // Range and checks from the raw inputs.
  logic signed [P-1:0] org, first_c, last_c;
  logic [2:0]          code_c;
  always_comb begin
    case (whence)
      brl_pkg::WH_START: org = '0;
      brl_pkg::WH_CUR:   org = P'({1'b0, cur_pos});
      brl_pkg::WH_END:   org = P'({1'b0, file_size});
      default:           org = '0;
    endcase
    first_c = org + P'(start_req);
    last_c  = (length == 32'sd0) ? P'(brl_pkg::IntMax) : first_c + P'(length) - P'(1);
    code_c = brl_pkg::ST_OK;
    if (lock_mode == brl_pkg::LK_BAD || req_type == brl_pkg::REQ_BAD ||
        (req_type == brl_pkg::REQ_QUERY && lock_mode == brl_pkg::LK_UNLOCK) ||
        !is_regular)
      code_c = brl_pkg::ST_INVALID;
    else if (req_type != brl_pkg::REQ_QUERY &&
             ((lock_mode == brl_pkg::LK_READ && !can_read) ||
              (lock_mode == brl_pkg::LK_WRITE && !can_write)))
      code_c = brl_pkg::ST_ACCESS;
    else if (whence == brl_pkg::WH_BAD || last_c < first_c)
      code_c = brl_pkg::ST_INVALID;
  end

  // First free entry (priority search over valid codes).
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (e_type[k] == brl_pkg::LK_UNLOCK) begin
        free_any = 1'b1;
        free_idx = I'(k);
      end
    end
  end

  logic ovl, cand;
  always_comb begin
    ovl = !(last < e_first[idx] || first > e_last[idx]);
    cand = e_type[idx] != brl_pkg::LK_UNLOCK && e_file[idx] == r_fid && ovl &&
           !(r_lt == brl_pkg::LK_READ && e_type[idx] == brl_pkg::LK_READ) &&
           !(r_lt != brl_pkg::LK_UNLOCK && e_owner[idx] == r_own);
    stat.bad        = bad;
    stat.bad_code   = bad_code;
    stat.is_query   = r_req == brl_pkg::REQ_QUERY;
    stat.is_unlock  = r_lt == brl_pkg::LK_UNLOCK;
    stat.is_setw    = r_req == brl_pkg::REQ_SETW;
    stat.last_idx   = idx == I'(N - 1);
    stat.hit        = cand;
    stat.lo_cov     = first <= e_first[idx];
    stat.hi_cov     = last >= e_last[idx];
    stat.covers     = stat.lo_cov && stat.hi_cov;
    stat.has_free   = free_any;
  end

  logic signed [P-1:0] len_c;
  assign len_c = e_last[idx] - e_first[idx] + P'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) e_type[k] <= brl_pkg::LK_UNLOCK;
      idx       <= '0;
      wake      <= 1'b0;
      rep_found <= 1'b0;
      bad       <= 1'b0;
    end else begin
      if (cmd.load) begin
        r_req <= req_type;  r_lt <= lock_mode;
        r_own <= owner;     r_fid <= file_id;
        first <= first_c;   last <= last_c;
        bad <= code_c != brl_pkg::ST_OK;
        bad_code <= code_c;
        wake <= 1'b0;
        rep_found <= 1'b0;
        rep_type <= '0; rep_start <= '0; rep_length <= '0; rep_owner <= '0;
      end
      if (cmd.idx_clr) idx <= '0;
      else if (cmd.idx_inc) idx <= idx + I'(1);
      if (cmd.set_wake) wake <= 1'b1;
      if (cmd.report) begin
        rep_found  <= 1'b1;
        rep_type   <= e_type[idx];
        rep_start  <= e_first[idx][32:0];
        rep_length <= len_c[32:0];
        rep_owner  <= e_owner[idx];
      end
      if (cmd.do_remove) e_type[idx] <= brl_pkg::LK_UNLOCK;
      if (cmd.do_trim_lo) e_first[idx] <= last + P'(1);
      if (cmd.do_trim_hi) e_last[idx] <= first - P'(1);
      if (cmd.do_split) begin
        e_type[free_idx]  <= e_type[idx];
        e_owner[free_idx] <= e_owner[idx];
        e_file[free_idx]  <= e_file[idx];
        e_first[free_idx] <= last + P'(1);
        e_last[free_idx]  <= e_last[idx];
        e_last[idx]       <= first - P'(1);
      end
      // A set request leaves the table untouched during its scan, so the
      // first free entry now is the first free entry the scan passed.
      if (cmd.do_insert) begin
        e_type[free_idx]  <= r_lt;
        e_owner[free_idx] <= r_own;
        e_file[free_idx]  <= r_fid;
        e_first[free_idx] <= first;
        e_last[free_idx]  <= last;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_split_free: assert property (@(posedge clk) disable iff (rst)
    cmd.do_split |-> free_any) else $error("split without free entry");
  a_insert_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.do_insert |-> free_any) else $error("insert without free slot");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.do_remove, cmd.do_trim_lo, cmd.do_trim_hi, cmd.do_split,
              cmd.do_insert}))
    else $error("several table writes at once");
`endif

endmodule

/* sv/brl_ctrl.sv */
// ----------------------------------------------------------------------------
// Byte-range lock controller
// Sequences check, table scan, update and result strobe.
// ----------------------------------------------------------------------------
module brl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output logic [2:0]         status,
  output brl_pkg::brl_cmd_t  cmd,
  input  brl_pkg::brl_stat_t stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state, state_next;
  logic [2:0] code, code_next;

  assign busy = state != S_IDLE;

  always_comb begin
    cmd = '0;
    state_next = state;
    code_next = code;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.idx_clr = 1'b1;
          code_next = brl_pkg::ST_OK;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.bad) begin
          code_next = stat.bad_code;
          state_next = S_FIN;
        end else if (stat.hit && !stat.is_unlock) begin
          cmd.report = 1'b1;
          if (!stat.is_query)
            code_next = stat.is_setw ? brl_pkg::ST_WAIT : brl_pkg::ST_BLOCK;
          state_next = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          if (stat.hit) begin
            cmd.set_wake = 1'b1;
            if (stat.covers) cmd.do_remove = 1'b1;
            else if (stat.lo_cov) cmd.do_trim_lo = 1'b1;
            else if (stat.hi_cov) cmd.do_trim_hi = 1'b1;
            else if (stat.has_free) cmd.do_split = 1'b1;
            else begin
              cmd.idx_inc = 1'b0;
              cmd.set_wake = 1'b0;
              code_next = brl_pkg::ST_NOFREE;
              state_next = S_FIN;
            end
          end
          if (cmd.idx_inc && stat.last_idx) begin
            state_next = S_FIN;
            if (!stat.is_query && !stat.is_unlock) begin
              if (stat.has_free) cmd.do_insert = 1'b1;
              else code_next = brl_pkg::ST_NOFREE;
            end
          end
        end
      end
      S_FIN: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign status = code;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code <= brl_pkg::ST_OK;
    end else begin
      state <= state_next;
      code <= code_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_fin: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after result");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE) else $error("load outside idle");
  a_scan_next: assert property (@(posedge clk) disable iff (rst)
    ($past(cmd.load) && !$past(rst)) |-> state == S_SCAN)
    else $error("no scan after load");
`endif

endmodule
